### rtl/lwfs_pkg.sv
// shared types and constants for the lcd window fill streamer
`timescale 1ns / 1ps

package lwfs_pkg;

    // input command codes
    localparam logic [1:0] CMD_FILL_RECT  = 2'd0;
    localparam logic [1:0] CMD_FILL_TICK  = 2'd1;
    localparam logic [1:0] CMD_IMAGE_WIN  = 2'd2;
    localparam logic [1:0] CMD_IMAGE_PIX  = 2'd3;

    // display controller opcodes
    localparam logic [7:0] OP_COLUMN = 8'h2A;
    localparam logic [7:0] OP_PAGE   = 8'h2B;
    localparam logic [7:0] OP_WRITE  = 8'h2C;

    // byte counts of the two run kinds
    localparam int HDR_LEN   = 11;
    localparam int PIX_LEN   = 2;
    localparam int IDX_W     = 4;

    // span of a clipped window side fits 9 bits, the pixel count 17 bits
    localparam int SPAN_W    = 9;
    localparam int CNT_W     = 17;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FILL  = 2'd1,
        MODE_IMAGE = 2'd2
    } mode_t;

    typedef enum logic {
        RUN_HEADER = 1'b0,
        RUN_PIXEL  = 1'b1
    } run_kind_t;

    // one run of output bytes, handed from decode to serializer
    typedef struct packed {
        run_kind_t   kind;
        logic [15:0] xs;
        logic [15:0] xe;
        logic [15:0] ys;
        logic [15:0] ye;
        logic [15:0] pix;
        logic        frame_done;
    } run_desc_t;

endpackage

### rtl/lcd_window_fill_streamer_top.sv
// top level of the lcd window fill streamer
//
// Takes window and pixel commands on the s_ channel and sends the display
// byte stream on the m_ channel, one byte per transfer, with is_data giving
// the select line and last_of_run closing the bytes of each command.
// A fill rectangle or image window that survives clipping yields the
// 11-byte header (column, page and write opcodes with their coordinates);
// a fill tick or image pixel yields the high and low color bytes while the
// window still has pixels. Commands that are dropped yield no transfer.
// Path: a command is held in the input register, decoded as it moves
// into the run buffer, and each byte is registered in the output register.
// Throughput: the output register moves one byte per cycle unless m_ready
// stalls it; a pixel command gives 2 bytes and a window command 11; the
// input register and run buffer let the next command in while bytes drain.
// Reset (aresetn low, synchronous) empties all stages and returns to idle
// with no window armed. When the receiver stalls, the output register
// holds its byte, the run buffer holds its place and s_ready drops once
// the input register is also full.
`timescale 1ns / 1ps

module lcd_window_fill_streamer_top
    import lwfs_pkg::*;
#(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 240
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_x_start,
    input  logic [15:0] s_y_start,
    input  logic [15:0] s_x_end,
    input  logic [15:0] s_y_end,
    input  logic [15:0] s_win_width,
    input  logic [15:0] s_win_height,
    input  logic [15:0] s_color,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_is_data,
    output logic        m_last_of_run,
    output logic        m_frame_done
);

    logic        in_valid_reg;
    logic [1:0]  cmd_reg;
    logic [15:0] x_start_reg, y_start_reg, x_end_reg, y_end_reg;
    logic [15:0] win_width_reg, win_height_reg, color_reg;

    logic        run_free, dec_take, desc_valid;
    run_desc_t   desc;

    assign dec_take = in_valid_reg && run_free;
    assign s_ready  = !in_valid_reg || dec_take;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg        <= s_cmd;
            x_start_reg    <= s_x_start;
            y_start_reg    <= s_y_start;
            x_end_reg      <= s_x_end;
            y_end_reg      <= s_y_end;
            win_width_reg  <= s_win_width;
            win_height_reg <= s_win_height;
            color_reg      <= s_color;
        end
    end

    // decode and window state
    lwfs_decode #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (dec_take),
        .cmd        (cmd_reg),
        .x_start    (x_start_reg),
        .y_start    (y_start_reg),
        .x_end      (x_end_reg),
        .y_end      (y_end_reg),
        .win_width  (win_width_reg),
        .win_height (win_height_reg),
        .color      (color_reg),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    // byte serializer
    lwfs_serializer u_serializer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (dec_take && desc_valid),
        .desc          (desc),
        .run_free      (run_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_is_data     (m_is_data),
        .m_last_of_run (m_last_of_run),
        .m_frame_done  (m_frame_done)
    );

endmodule

### rtl/lwfs_decode.sv
// command decode: panel clipping, window state and pixel counter
`timescale 1ns / 1ps

module lwfs_decode
    import lwfs_pkg::*;
#(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 240
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        take,
    input  logic [1:0]  cmd,
    input  logic [15:0] x_start,
    input  logic [15:0] y_start,
    input  logic [15:0] x_end,
    input  logic [15:0] y_end,
    input  logic [15:0] win_width,
    input  logic [15:0] win_height,
    input  logic [15:0] color,
    output logic        desc_valid,
    output run_desc_t   desc
);

    localparam logic [15:0] PW      = 16'(PANEL_WIDTH);
    localparam logic [15:0] PH      = 16'(PANEL_HEIGHT);
    localparam logic [15:0] PW_LAST = 16'(PANEL_WIDTH - 1);
    localparam logic [15:0] PH_LAST = 16'(PANEL_HEIGHT - 1);

    mode_t              mode_reg, mode_next;
    logic [CNT_W-1:0]   pixels_left_reg, pixels_left_next;
    logic [15:0]        fill_color_reg, fill_color_next;

    logic               start_on_panel;
    logic [15:0]        fill_xe, fill_ye;
    logic [15:0]        room_x, room_y, img_w, img_h;
    logic [15:0]        win_xe, win_ye;
    logic [15:0]        span_x, span_y;
    logic [CNT_W-1:0]   win_count;
    logic               window_ok;
    logic               pixel_ok;

    // clip the window to the panel
    always_comb begin
        start_on_panel = (x_start < PW) && (y_start < PH);
        fill_xe = (x_end >= PW) ? PW_LAST : x_end;
        fill_ye = (y_end >= PH) ? PH_LAST : y_end;
        room_x  = PW - x_start;
        room_y  = PH - y_start;
        img_w   = (win_width  > room_x) ? room_x : win_width;
        img_h   = (win_height > room_y) ? room_y : win_height;
        if (cmd == CMD_FILL_RECT) begin
            win_xe    = fill_xe;
            win_ye    = fill_ye;
            window_ok = start_on_panel && (fill_xe >= x_start) && (fill_ye >= y_start);
        end else begin
            win_xe    = x_start + img_w - 16'd1;
            win_ye    = y_start + img_h - 16'd1;
            window_ok = start_on_panel && (win_width != 16'd0) && (win_height != 16'd0);
        end
        span_x    = win_xe - x_start + 16'd1;
        span_y    = win_ye - y_start + 16'd1;
        win_count = CNT_W'(span_x[SPAN_W-1:0]) * CNT_W'(span_y[SPAN_W-1:0]);
    end

    // pick the run and the next state
    always_comb begin
        mode_next        = mode_reg;
        pixels_left_next = pixels_left_reg;
        fill_color_next  = fill_color_reg;
        desc_valid       = 1'b0;
        pixel_ok         = 1'b0;
        desc.kind        = RUN_HEADER;
        desc.xs          = x_start;
        desc.xe          = win_xe;
        desc.ys          = y_start;
        desc.ye          = win_ye;
        desc.pix         = color;
        desc.frame_done  = 1'b0;
        case (cmd)
            CMD_FILL_RECT, CMD_IMAGE_WIN: begin
                if (window_ok) begin
                    desc_valid       = 1'b1;
                    pixels_left_next = win_count;
                    if (cmd == CMD_FILL_RECT) begin
                        mode_next       = MODE_FILL;
                        fill_color_next = color;
                    end else begin
                        mode_next = MODE_IMAGE;
                    end
                end
            end
            default: begin
                if (cmd == CMD_FILL_TICK) begin
                    pixel_ok = (mode_reg == MODE_FILL);
                    desc.pix = fill_color_reg;
                end else begin
                    pixel_ok = (mode_reg == MODE_IMAGE);
                end
                if (pixel_ok && (pixels_left_reg != '0)) begin
                    desc_valid       = 1'b1;
                    desc.kind        = RUN_PIXEL;
                    pixels_left_next = pixels_left_reg - CNT_W'(1);
                    if (pixels_left_reg == CNT_W'(1)) begin
                        desc.frame_done = 1'b1;
                        mode_next       = MODE_IDLE;
                    end
                end
            end
        endcase
    end

    // window state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            pixels_left_reg <= '0;
            fill_color_reg  <= '0;
        end else if (take) begin
            mode_reg        <= mode_next;
            pixels_left_reg <= pixels_left_next;
            fill_color_reg  <= fill_color_next;
        end
    end

endmodule

### rtl/lwfs_serializer.sv
// run buffer and output register: one byte per transfer
`timescale 1ns / 1ps

module lwfs_serializer
    import lwfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  run_desc_t   desc,
    output logic        run_free,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_is_data,
    output logic        m_last_of_run,
    output logic        m_frame_done
);

    run_desc_t          run_reg;
    logic               busy_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               m_valid_reg;
    logic [7:0]         byte_reg;
    logic               is_data_reg, last_reg, frame_done_reg;

    logic               out_free, advance;
    logic [7:0]         sel_byte;
    logic               sel_data, sel_last, sel_frame;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = busy_reg && out_free;
    assign run_free = !busy_reg || (advance && sel_last);

    // byte at the current run position
    always_comb begin
        sel_byte  = 8'h00;
        sel_data  = 1'b1;
        sel_last  = 1'b0;
        sel_frame = 1'b0;
        if (run_reg.kind == RUN_PIXEL) begin
            if (idx_reg == IDX_W'(0)) begin
                sel_byte = run_reg.pix[15:8];
            end else begin
                sel_byte  = run_reg.pix[7:0];
                sel_last  = 1'b1;
                sel_frame = run_reg.frame_done;
            end
        end else begin
            case (idx_reg)
                4'd0:    begin sel_byte = OP_COLUMN; sel_data = 1'b0; end
                4'd1:    sel_byte = run_reg.xs[15:8];
                4'd2:    sel_byte = run_reg.xs[7:0];
                4'd3:    sel_byte = run_reg.xe[15:8];
                4'd4:    sel_byte = run_reg.xe[7:0];
                4'd5:    begin sel_byte = OP_PAGE; sel_data = 1'b0; end
                4'd6:    sel_byte = run_reg.ys[15:8];
                4'd7:    sel_byte = run_reg.ys[7:0];
                4'd8:    sel_byte = run_reg.ye[15:8];
                4'd9:    sel_byte = run_reg.ye[7:0];
                default: begin
                    sel_byte = OP_WRITE;
                    sel_data = 1'b0;
                    sel_last = 1'b1;
                end
            endcase
        end
    end

    // run position and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                m_valid_reg <= busy_reg;
            end
            if (load) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (advance) begin
                if (sel_last) begin
                    busy_reg <= 1'b0;
                end
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            run_reg <= desc;
        end
        if (advance) begin
            byte_reg       <= sel_byte;
            is_data_reg    <= sel_data;
            last_reg       <= sel_last;
            frame_done_reg <= sel_frame;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_is_data     = is_data_reg;
    assign m_last_of_run = last_reg;
    assign m_frame_done  = frame_done_reg;

endmodule
